>>> hw/rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and codes for the checked integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package cia_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  localparam logic [3:0] KIND_ADD = 4'd0;
  localparam logic [3:0] KIND_SUB = 4'd1;
  localparam logic [3:0] KIND_MUL = 4'd2;
  localparam logic [3:0] KIND_DIV = 4'd3;
  localparam logic [3:0] KIND_MOD = 4'd4;
  localparam logic [3:0] KIND_EQ  = 4'd5;
  localparam logic [3:0] KIND_NE  = 4'd6;
  localparam logic [3:0] KIND_LT  = 4'd7;
  localparam logic [3:0] KIND_GT  = 4'd8;
  localparam logic [3:0] KIND_LE  = 4'd9;
  localparam logic [3:0] KIND_GE  = 4'd10;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DIVZERO  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    CLS_SIMPLE,
    CLS_ZERODIV,
    CLS_MUL,
    CLS_DIV
  } op_class_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
    logic             neg;
    op_class_t        cls;
  } entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front
// Classifies an incoming operation and prepares operand magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none
module cia_front (
  input  wire logic [3:0]               kind,
  input  wire logic [cia_pkg::DataW-1:0] left_operand,
  input  wire logic [cia_pkg::DataW-1:0] right_operand,
  output cia_pkg::entry_t                entry
);

  always_comb begin
    entry.kind = kind;
    entry.a    = left_operand;
    entry.b    = right_operand;
    entry.ma   = left_operand[cia_pkg::DataW-1] ? (~left_operand + 1'b1) : left_operand;
    entry.mb   = right_operand[cia_pkg::DataW-1] ? (~right_operand + 1'b1) : right_operand;
    entry.neg  = left_operand[cia_pkg::DataW-1] ^ right_operand[cia_pkg::DataW-1];
    if (kind == cia_pkg::KIND_MUL) begin
      entry.cls = cia_pkg::CLS_MUL;
    end else if (kind == cia_pkg::KIND_DIV || kind == cia_pkg::KIND_MOD) begin
      // zero divisor resolves at once
      entry.cls = (right_operand == '0) ? cia_pkg::CLS_ZERODIV : cia_pkg::CLS_DIV;
    end else begin
      entry.cls = cia_pkg::CLS_SIMPLE;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cia_queue.sv
// ----------------------------------------------------------------------------
// cia_queue
// Short in-order queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module cia_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cia_pkg::entry_t push_entry,
  input  wire logic            pop,
  output cia_pkg::entry_t      head,
  output logic                 empty,
  output logic                 full
);

  cia_pkg::entry_t               slots [cia_pkg::QDepth];
  logic [cia_pkg::QPtrW-1:0]     wr_ptr;
  logic [cia_pkg::QPtrW-1:0]     rd_ptr;
  logic [cia_pkg::QPtrW:0]       count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (cia_pkg::QPtrW+1)'(cia_pkg::QDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (cia_pkg::QPtrW+1)'(push) - (cia_pkg::QPtrW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cia_back.sv
// ----------------------------------------------------------------------------
// cia_back
// Executes queued operations: simple ops straight from idle, a sequenced
// multiplier and a radix-2 divider, then drives the registered result.
// ----------------------------------------------------------------------------
`default_nettype none
module cia_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cia_pkg::entry_t           head,
  input  wire logic                      empty,
  output logic                           pop,
  output logic                           done,
  output logic [cia_pkg::DataW-1:0]      result_value,
  output logic [1:0]                     status
);

  localparam int unsigned W = cia_pkg::DataW;
  localparam int unsigned H = W / 2;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;
  localparam logic [W-1:0] SignBit = {1'b1, {(W-1){1'b0}}};

  logic [1:0]         state, state_next;
  logic [$clog2(W)-1:0] cnt, cnt_next;
  logic [W-1:0]       pp, pp_next;
  logic [1:0]         sh, sh_next;
  logic [2*W-1:0]     acc, acc_next;
  logic [W-1:0]       rem, rem_next;
  logic [W-1:0]       quo, quo_next;
  logic               done_next;
  logic [W-1:0]       res_next;
  logic [1:0]         st_next;

  logic [W-1:0] sum, dif, ba, bb, hi, lo, rt;
  logic [W:0]   rem_sh, trial;
  logic [H-1:0] ha, hb;
  logic [W-1:0] prod;

  always_comb begin
    sum = head.a + head.b;
    dif = head.a - head.b;
    ba  = head.a ^ SignBit;
    bb  = head.b ^ SignBit;
    hi  = acc[2*W-1:W];
    lo  = acc[W-1:0];
    rem_sh = {rem, quo[W-1]};
    trial  = rem_sh - {1'b0, head.mb};
    ha = cnt[1] ? head.ma[W-1:H] : head.ma[H-1:0];
    hb = cnt[0] ? head.mb[W-1:H] : head.mb[H-1:0];
    prod = ha * hb;
    rt = head.a[W-1] ? (~rem + 1'b1) : rem;
    if (rem != '0 && head.neg) rt = rt + head.b;

    state_next = state;
    cnt_next   = cnt;
    pp_next    = pp;
    sh_next    = sh;
    acc_next   = acc;
    rem_next   = rem;
    quo_next   = quo;
    done_next  = 1'b0;
    res_next   = '0;
    st_next    = cia_pkg::STATUS_OK;
    pop        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          unique case (head.cls)
            cia_pkg::CLS_SIMPLE: begin
              pop = 1'b1;
              done_next = 1'b1;
              unique case (head.kind)
                cia_pkg::KIND_ADD: begin
                  if (((head.a ^ sum) & (head.b ^ sum) & SignBit) != '0)
                    st_next = cia_pkg::STATUS_OVERFLOW;
                  else res_next = sum;
                end
                cia_pkg::KIND_SUB: begin
                  if (((head.a ^ head.b) & (head.a ^ dif) & SignBit) != '0)
                    st_next = cia_pkg::STATUS_OVERFLOW;
                  else res_next = dif;
                end
                cia_pkg::KIND_EQ: res_next = W'(head.a == head.b);
                cia_pkg::KIND_NE: res_next = W'(head.a != head.b);
                cia_pkg::KIND_LT: res_next = W'(ba < bb);
                cia_pkg::KIND_GT: res_next = W'(ba > bb);
                cia_pkg::KIND_LE: res_next = W'(ba <= bb);
                cia_pkg::KIND_GE: res_next = W'(ba >= bb);
                default: res_next = '0;
              endcase
            end
            cia_pkg::CLS_ZERODIV: begin
              pop = 1'b1;
              done_next = 1'b1;
              st_next = cia_pkg::STATUS_DIVZERO;
            end
            cia_pkg::CLS_MUL: begin
              cnt_next = '0;
              acc_next = '0;
              state_next = S_MUL;
            end
            cia_pkg::CLS_DIV: begin
              cnt_next = '0;
              rem_next = '0;
              quo_next = head.ma;
              state_next = S_DIV;
            end
          endcase
        end
      end
      S_MUL: begin
        // multiply one half pair, add the previous partial product
        if (cnt != '0) begin
          acc_next = acc + ({{W{1'b0}}, pp} << (H * sh));
        end
        pp_next  = prod;
        sh_next  = 2'(cnt[0]) + 2'(cnt[1]);
        cnt_next = cnt + 1'b1;
        if (cnt == 4) state_next = S_FIN;
      end
      S_DIV: begin
        if (!trial[W]) begin
          rem_next = trial[W-1:0];
          quo_next = {quo[W-2:0], 1'b1};
        end else begin
          rem_next = rem_sh[W-1:0];
          quo_next = {quo[W-2:0], 1'b0};
        end
        cnt_next = cnt + 1'b1;
        if (cnt == '1) state_next = S_FIN;
      end
      S_FIN: begin
        pop = 1'b1;
        done_next = 1'b1;
        state_next = S_IDLE;
        if (head.cls == cia_pkg::CLS_MUL) begin
          if (hi != '0 || (head.neg ? (lo > SignBit) : (lo >= SignBit)))
            st_next = cia_pkg::STATUS_OVERFLOW;
          else res_next = head.neg ? (~lo + 1'b1) : lo;
        end else if (head.kind == cia_pkg::KIND_MOD) begin
          res_next = rt;
        end else if (!head.neg) begin
          if (quo[W-1]) st_next = cia_pkg::STATUS_OVERFLOW;
          else res_next = quo;
        end else begin
          res_next = ~quo + 1'b1 - W'(rem != '0);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    pp  <= pp_next;
    sh  <= sh_next;
    acc <= acc_next;
    rem <= rem_next;
    quo <= quo_next;
    result_value <= res_next;
    status <= st_next;
  end

endmodule
`default_nettype wire

>>> hw/rtl/checked_integer_alu_core.sv
// ----------------------------------------------------------------------------
// checked_integer_alu_core
// Checked signed 64-bit ALU with floored division and error status.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; each result
// appears on result_value/status for exactly one cycle with done high, in
// the order the operations were taken, and the receiver cannot stall it.
// Operations enter a four-deep queue, so start may be held high every cycle
// until the queue fills. Add, subtract, compare, unused codes and a zero
// divisor finish in the cycle after reaching the queue head; multiply runs
// in the back end as four 32x32 partial products on one multiplier; divide
// and modulo produce one quotient bit per cycle.
`default_nettype none
module checked_integer_alu_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [3:0]                kind,
  input  wire logic [cia_pkg::DataW-1:0] left_operand,
  input  wire logic [cia_pkg::DataW-1:0] right_operand,
  output logic                           done,
  output logic [cia_pkg::DataW-1:0]      result_value,
  output logic [1:0]                     status
);

  cia_pkg::entry_t in_entry;
  cia_pkg::entry_t head;
  logic            empty;
  logic            full;
  logic            pop;

  // classify the operation on its way into the queue
  cia_front u_front (
    .kind          (kind),
    .left_operand  (left_operand),
    .right_operand (right_operand),
    .entry         (in_entry)
  );

  // hold off new transfers only when the queue is full
  assign busy = full;

  cia_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (start && !full),
    .push_entry (in_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  // execute the head entry and drop it once its result is launched
  cia_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .done         (done),
    .result_value (result_value),
    .status       (status)
  );

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checked integer ALU: directed corner cases go
// without gaps, random operations with random gaps, and each done strobe
// is compared with a floored-division, overflow-checked prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG1  = '1;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  kind;
  logic [63:0] left_operand;
  logic [63:0] right_operand;
  logic        done;
  logic [63:0] result_value;
  logic [1:0]  status;

  // expected transfers, oldest first: {value, status}
  logic [65:0] expected_q[$];
  int          mismatches;
  int unsigned cycle_count;

  checked_integer_alu_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .left_operand(left_operand), .right_operand(right_operand),
    .done(done), .result_value(result_value), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Compute the expected value and status of one operation.
  function automatic logic [65:0] alu_predict(logic [3:0] op, logic [63:0] a,
                                              logic [63:0] b);
    logic signed [127:0] wide;
    logic signed [64:0]  sa;
    logic signed [64:0]  sb;
    logic signed [64:0]  q;
    logic signed [64:0]  r;
    logic [63:0]         res;
    logic [1:0]          st;
    res = '0;
    st  = cia_pkg::STATUS_OK;
    sa  = {a[63], a};
    sb  = {b[63], b};
    case (op)
      cia_pkg::KIND_ADD: begin
        q = sa + sb;
        if (q[64] != q[63]) st = cia_pkg::STATUS_OVERFLOW; else res = q[63:0];
      end
      cia_pkg::KIND_SUB: begin
        q = sa - sb;
        if (q[64] != q[63]) st = cia_pkg::STATUS_OVERFLOW; else res = q[63:0];
      end
      cia_pkg::KIND_MUL: begin
        wide = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        if (wide[127:63] != {65{wide[63]}}) st = cia_pkg::STATUS_OVERFLOW;
        else res = wide[63:0];
      end
      cia_pkg::KIND_DIV, cia_pkg::KIND_MOD: begin
        if (b == '0) begin
          st = cia_pkg::STATUS_DIVZERO;
        end else begin
          // 65-bit signed division truncates; floor it by hand
          q = sa / sb;
          r = sa % sb;
          if (r != 0 && (r[64] != sb[64])) begin
            q = q - 1;
            r = r + sb;
          end
          if (op == cia_pkg::KIND_MOD) res = r[63:0];
          else if (q[64] != q[63]) st = cia_pkg::STATUS_OVERFLOW;
          else res = q[63:0];
        end
      end
      cia_pkg::KIND_EQ: res = {63'd0, a == b};
      cia_pkg::KIND_NE: res = {63'd0, a != b};
      cia_pkg::KIND_LT: res = {63'd0, $signed(a) <  $signed(b)};
      cia_pkg::KIND_GT: res = {63'd0, $signed(a) >  $signed(b)};
      cia_pkg::KIND_LE: res = {63'd0, $signed(a) <= $signed(b)};
      cia_pkg::KIND_GE: res = {63'd0, $signed(a) >= $signed(b)};
      default: res = '0;
    endcase
    if (st != cia_pkg::STATUS_OK) res = '0;
    return {res, st};
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Short gaps mostly, sometimes none, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 40) n = 0;
    else if (pick < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 80);
    return n;
  endfunction

  // Send one operation; hold start until the transfer happens.
  task automatic send_op(input logic [3:0] op, input logic [63:0] a,
                         input logic [63:0] b, input bit gaps);
    int unsigned gap;
    start         <= 1'b1;
    kind          <= op;
    left_operand  <= a;
    right_operand <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(alu_predict(op, a, b));
    gap = 0;
    if (gaps && $urandom_range(0, 3) != 0) gap = idle_len();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Check each result on the edge that ends its done cycle.
  always @(posedge clk) begin
    logic [65:0] exp_item;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        exp_item = expected_q.pop_front();
        if (result_value !== exp_item[65:2])
          report_mismatch($sformatf("value %h expected %h", result_value,
                                    exp_item[65:2]));
        if (status !== exp_item[1:0])
          report_mismatch($sformatf("status %0d expected %0d", status,
                                    exp_item[1:0]));
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("checked_integer_alu_core test failed");
      $finish;
    end
  end

  // Pick an operand: boundaries, small or 32-bit values, or fully random bits.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return MIN64 + $urandom_range(0, 2);
      1: return MAX64 - $urandom_range(0, 2);
      2: return 64'($signed($urandom_range(0, 20)) - 10);
      3: return {{32{1'b0}}, $urandom()};
      4: return {{33{1'b1}}, 31'($urandom())};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Directed: boundary operands for every operation code.
  task automatic test_corners();
    logic [63:0] vals[6];
    vals = '{MIN64, MAX64, NEG1, 64'd0, 64'd1, 64'd7};
    for (int op = 0; op < 16; op++)
      send_op(4'(op), vals[op % 6], vals[(op + 2) % 6], 1'b0);
    send_op(cia_pkg::KIND_DIV, MIN64, NEG1, 1'b0);
    send_op(cia_pkg::KIND_MOD, MIN64, NEG1, 1'b0);
    send_op(cia_pkg::KIND_DIV, 64'd5, 64'd0, 1'b0);
    send_op(cia_pkg::KIND_MOD, 64'd5, 64'd0, 1'b0);
    send_op(cia_pkg::KIND_DIV, -64'sd7, 64'd2, 1'b0);
    send_op(cia_pkg::KIND_MOD, 64'd7, -64'sd2, 1'b0);
    send_op(cia_pkg::KIND_MUL, MIN64, NEG1, 1'b0);
    send_op(cia_pkg::KIND_MUL, MIN64, 64'd1, 1'b0);
    send_op(cia_pkg::KIND_ADD, MAX64, 64'd1, 1'b0);
  endtask

  // Random: all codes including unused ones, with random gaps.
  task automatic test_random(input int unsigned count);
    logic [3:0] op;
    for (int unsigned i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                        : 4'($urandom_range(0, 10));
      send_op(op, pick_operand(), pick_operand(), 1'b1);
    end
  endtask

  initial begin
    rst           <= 1'b1;
    start         <= 1'b0;
    kind          <= '0;
    left_operand  <= '0;
    right_operand <= '0;
    mismatches    = 0;
    cycle_count   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corners();
    test_random(525);
    start <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("checked_integer_alu_core test passed");
    end else begin
      $display("checked_integer_alu_core test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cia_pkg.sv
hw/rtl/cia_front.sv
hw/rtl/cia_queue.sv
hw/rtl/cia_back.sv
hw/rtl/checked_integer_alu_core.sv
test/tb_top.sv
